[rtl/core/assert_macros.svh]
// Assertion macros used by the top level RTL file of the codebook search block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define GCNS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define GCNS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/gcns_pkg.sv]
// Types and constants of the gain codebook nearest search block.
package gcns_pkg;

  typedef logic signed [15:0] sample_t;
  typedef logic [1:0]         mode_t;
  typedef logic [1:0]         cfg_idx_t;
  typedef logic [8:0]         cfg_data_t;
  typedef logic [9:0]         load_addr_t;
  typedef logic [7:0]         index_t;

  localparam mode_t MODE_SCALAR   = 2'd0;
  localparam mode_t MODE_PAIR_Q12 = 2'd1;
  localparam mode_t MODE_PAIR_Q11 = 2'd2;
  localparam mode_t MODE_QUAD     = 2'd3;

  localparam cfg_idx_t CFG_SEARCH_MODE = 2'd0;
  localparam cfg_idx_t CFG_TABLE_SIZE  = 2'd1;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam int unsigned MAG_W  = 17;
  localparam int unsigned PROD_W = 23;
  localparam int unsigned T_W    = 12;
  localparam int unsigned SQ_W   = 24;
  localparam int unsigned DIST_W = 26;

  localparam logic [PROD_W-1:0] SCALE        = PROD_W'(100);
  localparam logic [MAG_W-1:0]  SCALAR_LIMIT = MAG_W'(17'hFFFF);

  // Position of a codebook word inside its group and group boundaries.
  typedef struct packed {
    logic       first;
    logic       last;
    logic [1:0] pos;
  } tag_t;

endpackage

[rtl/core/gcns_cb_mem.sv]
// Codebook store: one write port, one read port with registered read data.
module gcns_cb_mem #(
  parameter int unsigned TABLE_WORDS = 1024
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(TABLE_WORDS)-1:0] waddr_i,
  input  gcns_pkg::sample_t              wdata_i,
  input  logic                           re_i,
  input  logic [$clog2(TABLE_WORDS)-1:0] raddr_i,
  output gcns_pkg::sample_t              rdata_o
);
  import gcns_pkg::*;

  sample_t mem_q [TABLE_WORDS];
  sample_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/gcns_term.sv]
// Distance term pipeline: absolute difference, scaling, and squaring.
module gcns_term (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  gcns_pkg::mode_t                mode_i,
  input  gcns_pkg::sample_t              new_gain0_i,
  input  gcns_pkg::sample_t              old_pitch0_i,
  input  gcns_pkg::sample_t              new_gain1_i,
  input  gcns_pkg::sample_t              old_pitch1_i,
  input  logic                           in_valid_i,
  input  gcns_pkg::tag_t                 in_tag_i,
  input  gcns_pkg::sample_t              in_word_i,
  output logic                           out_valid_o,
  output gcns_pkg::tag_t                 out_tag_o,
  output logic [gcns_pkg::MAG_W-1:0]     out_mag_o,
  output logic [gcns_pkg::SQ_W-1:0]      out_sq_o,
  output logic                           busy_o
);
  import gcns_pkg::*;

  sample_t                   target;
  logic signed [MAG_W-1:0]   diff;
  logic [MAG_W-1:0]          mag;
  logic [PROD_W-1:0]         prod;
  logic [T_W-1:0]            scaled;

  logic                      v2_q, v3_q;
  tag_t                      tag2_q, tag3_q;
  logic [MAG_W-1:0]          mag2_q, mag3_q;
  logic [T_W-1:0]            t2_q;
  logic [SQ_W-1:0]           sq3_q;

  always_comb begin
    if (mode_i == MODE_SCALAR) begin
      target = new_gain0_i;
    end else begin
      case (in_tag_i.pos)
        2'd0:    target = old_pitch0_i;
        2'd1:    target = new_gain0_i;
        2'd2:    target = old_pitch1_i;
        2'd3:    target = new_gain1_i;
        default: target = old_pitch0_i;
      endcase
    end
  end

  assign diff = $signed({in_word_i[15], in_word_i}) - $signed({target[15], target});
  assign mag  = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
  assign prod = PROD_W'(mag) * SCALE;

  // Pitch words are Q14; gain words are Q12, or Q11 in the second pair mode.
  always_comb begin
    if (!in_tag_i.pos[0]) begin
      scaled = T_W'(prod >> 14);
    end else if (mode_i == MODE_PAIR_Q11) begin
      scaled = T_W'(prod >> 11);
    end else begin
      scaled = T_W'(prod >> 12);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v2_q <= in_valid_i;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tag2_q <= in_tag_i;
    mag2_q <= mag;
    t2_q   <= scaled;
    tag3_q <= tag2_q;
    mag3_q <= mag2_q;
    sq3_q  <= {{(SQ_W-T_W){1'b0}}, t2_q} * {{(SQ_W-T_W){1'b0}}, t2_q};
  end

  assign out_valid_o = v3_q;
  assign out_tag_o   = tag3_q;
  assign out_mag_o   = mag3_q;
  assign out_sq_o    = sq3_q;
  assign busy_o      = v2_q | v3_q;

endmodule

[rtl/core/gain_codebook_nearest_search_core.sv]
// Top level of the gain codebook nearest codeword search block.
//
//   channel   handshake                  payload
//   config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//   command   start_i / busy_o           cmd_i, load_addr_i, load_value_i, targets
//   result    done_o (one-cycle strobe)  best_index_o
//
// A load item is written when taken; the block stays free for the next item.
// A search reads one codebook word per cycle through the single memory read
// port: min(table_size, MAX_SEARCH_WORDS) words in scalar mode, that count
// rounded down to even in the pair modes, and TABLE_WORDS rounded down to a
// multiple of four in quad mode. A search that reads no word goes straight to
// the wait state. busy_o stays high for the whole search.
// Reset restores the control registers and leaves the codebook as it is; no clearing
// pass runs. The result cannot be stalled: done_o lasts exactly one cycle.
`include "assert_macros.svh"

module gain_codebook_nearest_search_core #(
  parameter int unsigned TABLE_WORDS      = 1024,
  parameter int unsigned MAX_SEARCH_WORDS = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  gcns_pkg::cfg_idx_t    cfg_index_i,
  input  gcns_pkg::cfg_data_t   cfg_data_i,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  cmd_i,
  input  gcns_pkg::load_addr_t  load_addr_i,
  input  gcns_pkg::sample_t     load_value_i,
  input  gcns_pkg::sample_t     new_gain0_i,
  input  gcns_pkg::sample_t     old_pitch0_i,
  input  gcns_pkg::sample_t     new_gain1_i,
  input  gcns_pkg::sample_t     old_pitch1_i,
  output gcns_pkg::index_t      best_index_o,
  output logic                  done_o
);
  import gcns_pkg::*;

  localparam int unsigned AW   = $clog2(TABLE_WORDS);
  localparam int unsigned MAXW = (TABLE_WORDS > MAX_SEARCH_WORDS) ?
                                 TABLE_WORDS : MAX_SEARCH_WORDS;
  localparam int unsigned CW   = $clog2(MAXW + 1);
  localparam int unsigned QUAD_WORDS = (TABLE_WORDS / 4) * 4;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0]         state_q, state_d;
  mode_t              mode_q;
  logic [8:0]         tsize_q;
  logic [CW-1:0]      cnt_q, lim_q, n_w, lim_w;
  logic               found_q, done_q;
  logic [DIST_W-1:0]  min_q, acc_q, distance;
  index_t             grp_q, best_q, res_q;
  sample_t            g0_q, p0_q, g1_q, p1_q;

  logic               accept, do_search, do_load, load_in_range;
  logic               rd_en, rd_inb;
  tag_t               rd_tag, tag1_q;
  logic               v1_q, inb1_q;
  sample_t            rdata, word1;

  logic               v3;
  tag_t               tag3;
  logic [MAG_W-1:0]   mag3;
  logic [SQ_W-1:0]    sq3;
  logic               pipe_busy;
  logic               better;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = (state_q != S_IDLE);
  assign accept      = start_i && !busy_o;
  assign do_search   = accept && (cmd_i == CMD_SEARCH);
  assign do_load     = accept && (cmd_i == CMD_LOAD);
  assign load_in_range = (32'(load_addr_i) < TABLE_WORDS);

  assign n_w = (32'(tsize_q) > MAX_SEARCH_WORDS) ? CW'(MAX_SEARCH_WORDS) : CW'(tsize_q);

  always_comb begin
    case (mode_q)
      MODE_SCALAR: lim_w = n_w;
      MODE_QUAD:   lim_w = CW'(QUAD_WORDS);
      default:     lim_w = {n_w[CW-1:1], 1'b0};
    endcase
  end

  // Read issue: one word per cycle while the scan runs.
  assign rd_en  = (state_q == S_RUN);
  assign rd_inb = (32'(cnt_q) < TABLE_WORDS);

  always_comb begin
    case (mode_q)
      MODE_SCALAR: begin
        rd_tag.pos  = 2'd0;
        rd_tag.last = 1'b1;
      end
      MODE_QUAD: begin
        rd_tag.pos  = cnt_q[1:0];
        rd_tag.last = (cnt_q[1:0] == 2'd3);
      end
      default: begin
        rd_tag.pos  = {1'b0, cnt_q[0]};
        rd_tag.last = cnt_q[0];
      end
    endcase
    rd_tag.first = (rd_tag.pos == 2'd0);
  end

  gcns_cb_mem #(
    .TABLE_WORDS (TABLE_WORDS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (do_load && load_in_range),
    .waddr_i (AW'(load_addr_i)),
    .wdata_i (load_value_i),
    .re_i    (rd_en && rd_inb),
    .raddr_i (cnt_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Words beyond the store read as zero.
  assign word1 = inb1_q ? rdata : '0;

  gcns_term u_term (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .mode_i       (mode_q),
    .new_gain0_i  (g0_q),
    .old_pitch0_i (p0_q),
    .new_gain1_i  (g1_q),
    .old_pitch1_i (p1_q),
    .in_valid_i   (v1_q),
    .in_tag_i     (tag1_q),
    .in_word_i    (word1),
    .out_valid_o  (v3),
    .out_tag_o    (tag3),
    .out_mag_o    (mag3),
    .out_sq_o     (sq3),
    .busy_o       (pipe_busy)
  );

  always_comb begin
    if (mode_q == MODE_SCALAR) begin
      distance = DIST_W'(mag3);
    end else begin
      distance = (tag3.first ? '0 : acc_q) + DIST_W'(sq3);
    end
  end

  // Strict compare keeps the earliest index on ties.
  assign better = !found_q || (distance < min_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (do_search) begin
          state_d = (lim_w == '0) ? S_WAIT : S_RUN;
        end
      end
      S_RUN: begin
        if (cnt_q == lim_q - CW'(1)) begin
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!v1_q && !pipe_busy) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= MODE_PAIR_Q12;
      tsize_q <= 9'd256;
      cnt_q   <= '0;
      lim_q   <= '0;
      v1_q    <= 1'b0;
      done_q  <= 1'b0;
      found_q <= 1'b0;
      grp_q   <= '0;
      best_q  <= '0;
    end else begin
      state_q <= state_d;
      v1_q    <= rd_en;
      done_q  <= (state_q == S_WAIT) && (state_d == S_IDLE);
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_SEARCH_MODE: mode_q  <= cfg_data_i[1:0];
          CFG_TABLE_SIZE:  tsize_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (do_search) begin
        cnt_q   <= '0;
        lim_q   <= lim_w;
        grp_q   <= '0;
        best_q  <= '0;
        found_q <= (mode_q == MODE_SCALAR);
      end else begin
        if (rd_en) begin
          cnt_q <= cnt_q + CW'(1);
        end
        if (v3 && tag3.last) begin
          grp_q <= grp_q + 8'd1;
          if (better) begin
            best_q  <= grp_q;
            found_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tag1_q <= rd_tag;
    inb1_q <= rd_inb;
    if (do_search) begin
      g0_q  <= new_gain0_i;
      p0_q  <= old_pitch0_i;
      g1_q  <= new_gain1_i;
      p1_q  <= old_pitch1_i;
      min_q <= DIST_W'(SCALAR_LIMIT);
    end else if (v3) begin
      if (!tag3.last) begin
        acc_q <= distance;
      end else if (better) begin
        min_q <= distance;
      end
    end
    if ((state_q == S_WAIT) && (state_d == S_IDLE)) begin
      res_q <= best_q;
    end
  end

  assign done_o       = done_q;
  assign best_index_o = res_q;

  `GCNS_ASSERT(a_idle_pipe_empty, (state_q == S_IDLE) |-> !(v1_q || pipe_busy), "busy pipe in idle")
  `GCNS_ASSERT(a_done_from_wait, done_q |-> $past(state_q == S_WAIT), "stray result strobe")
  `GCNS_ASSERT_NEXT(a_search_busy, do_search, busy_o, "search item did not raise busy")

endmodule

[sim/gain_codebook_nearest_search_core_test.sv]
// Self-checking testbench for the gain codebook nearest codeword search core.
`timescale 1ns / 1ps

module gain_codebook_nearest_search_core_test;
  import gcns_pkg::*;

  localparam int unsigned BOOK_WORDS    = 1024;
  localparam int unsigned MAX_SEARCH    = 256;
  localparam int unsigned SCALAR_CAP    = 32'hFFFF;
  localparam int unsigned SCALE_PCT     = 100;
  localparam int unsigned PITCH_DIV     = 16384;
  localparam int unsigned GAIN_Q12_DIV  = 4096;
  localparam int unsigned GAIN_Q11_DIV  = 2048;
  localparam int unsigned RANDOM_ITEMS  = 150;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned END_CYCLES    = 20;
  localparam int unsigned STALL_LIMIT   = 6000;
  localparam int unsigned QUIET_FROM    = 300;
  localparam int unsigned QUIET_TO      = 650;

  typedef struct {
    logic       cmd;
    load_addr_t addr;
    sample_t    value;
    sample_t    gain0;
    sample_t    pitch0;
    sample_t    gain1;
    sample_t    pitch1;
  } book_item_t;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       cfg_valid_i  = 1'b0;
  cfg_idx_t   cfg_index_i  = CFG_SEARCH_MODE;
  cfg_data_t  cfg_data_i   = '0;
  logic       start_i      = 1'b0;
  logic       cmd_i        = CMD_LOAD;
  load_addr_t load_addr_i  = '0;
  sample_t    load_value_i = '0;
  sample_t    new_gain0_i  = '0;
  sample_t    old_pitch0_i = '0;
  sample_t    new_gain1_i  = '0;
  sample_t    old_pitch1_i = '0;
  logic       cfg_ready_o;
  logic       busy_o;
  logic       done_o;
  index_t     best_index_o;

  // Predictor state: codebook copy and register settings, reset values included.
  sample_t    book_words [BOOK_WORDS];
  mode_t      cur_mode = MODE_PAIR_Q12;
  cfg_data_t  cur_size = 9'd256;

  book_item_t pending_items [$];
  index_t     expected_index [$];
  book_item_t driven_item;

  int unsigned items_queued   = 0;
  int unsigned items_accepted = 0;
  int unsigned load_count     = 0;
  int unsigned search_count   = 0;
  int unsigned quad_count     = 0;
  int unsigned checked_count  = 0;
  int unsigned setting_count  = 0;
  int unsigned fail_count     = 0;
  int unsigned stall_cycles   = 0;

  gain_codebook_nearest_search_core #(
    .TABLE_WORDS     (BOOK_WORDS),
    .MAX_SEARCH_WORDS(MAX_SEARCH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .cmd_i       (cmd_i),
    .load_addr_i (load_addr_i),
    .load_value_i(load_value_i),
    .new_gain0_i (new_gain0_i),
    .old_pitch0_i(old_pitch0_i),
    .new_gain1_i (new_gain1_i),
    .old_pitch1_i(old_pitch1_i),
    .best_index_o(best_index_o),
    .done_o      (done_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int unsigned word_gap(sample_t a, sample_t b);
    int sa;
    int sb;
    sa = a;
    sb = b;
    return (sa >= sb) ? int'(sa - sb) : int'(sb - sa);
  endfunction

  function automatic int unsigned scaled_square(sample_t w, sample_t t, int unsigned div);
    int unsigned s;
    s = (SCALE_PCT * word_gap(w, t)) / div;
    return s * s;
  endfunction

  function automatic index_t nearest_codeword(book_item_t it);
    int unsigned span;
    int unsigned gain_div;
    int unsigned distance;
    int unsigned closest;
    int unsigned best;
    bit          found;
    span    = (cur_size > MAX_SEARCH) ? MAX_SEARCH : cur_size;
    best    = 0;
    closest = 0;
    found   = 1'b0;
    case (cur_mode)
      MODE_SCALAR: begin
        // A gap at the cap never wins, so an all-far table yields index zero.
        closest = SCALAR_CAP;
        for (int unsigned i = 0; i < span; i++) begin
          distance = word_gap(book_words[i], it.gain0);
          if (distance < closest) begin
            closest = distance;
            best    = i;
          end
        end
      end
      MODE_QUAD: begin
        for (int unsigned i = 0; i + 4 <= BOOK_WORDS; i += 4) begin
          distance = scaled_square(book_words[i], it.pitch0, PITCH_DIV)
                   + scaled_square(book_words[i+1], it.gain0, GAIN_Q12_DIV)
                   + scaled_square(book_words[i+2], it.pitch1, PITCH_DIV)
                   + scaled_square(book_words[i+3], it.gain1, GAIN_Q12_DIV);
          if (!found || distance < closest) begin
            found   = 1'b1;
            closest = distance;
            best    = i / 4;
          end
        end
      end
      default: begin
        gain_div = (cur_mode == MODE_PAIR_Q12) ? GAIN_Q12_DIV : GAIN_Q11_DIV;
        for (int unsigned i = 0; i + 2 <= span; i += 2) begin
          distance = scaled_square(book_words[i], it.pitch0, PITCH_DIV)
                   + scaled_square(book_words[i+1], it.gain0, gain_div);
          if (!found || distance < closest) begin
            found   = 1'b1;
            closest = distance;
            best    = i / 2;
          end
        end
      end
    endcase
    return index_t'(best);
  endfunction

  // Mix of extremes, a coarse grid that breeds ties, values near zero or near stored words, and random ones.
  function automatic sample_t pick_sample(int unsigned span);
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return sample_t'($urandom_range(0, 15) * 4096);
      3: return sample_t'($urandom_range(0, 63)) - 16'sd32;
      4: return book_words[$urandom_range(0, span - 1)] + sample_t'($urandom_range(0, 6))
                - 16'sd3;
      default: return sample_t'($urandom());
    endcase
  endfunction

  task automatic queue_load(int unsigned addr, sample_t value);
    book_item_t it;
    it.cmd    = CMD_LOAD;
    it.addr   = load_addr_t'(addr);
    it.value  = value;
    it.gain0  = sample_t'($urandom());
    it.pitch0 = sample_t'($urandom());
    it.gain1  = sample_t'($urandom());
    it.pitch1 = sample_t'($urandom());
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic queue_search(sample_t g0, sample_t p0, sample_t g1, sample_t p1);
    book_item_t it;
    it.cmd    = CMD_SEARCH;
    it.addr   = load_addr_t'($urandom());
    it.value  = sample_t'($urandom());
    it.gain0  = g0;
    it.pitch0 = p0;
    it.gain1  = g1;
    it.pitch1 = p1;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Waits until every queued item is taken and answered and the core is free.
  task automatic wait_quiet();
    do @(posedge clk_i);
    while (pending_items.size() != 0 || start_i || busy_o !== 1'b0 ||
           expected_index.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_SEARCH_MODE) begin
      cur_mode = mode_t'(value[1:0]);
    end else begin
      cur_size = value;
    end
  endtask

  task automatic apply_setting(mode_t mode, cfg_data_t size);
    wait_quiet();
    write_reg(CFG_SEARCH_MODE, cfg_data_t'(mode));
    write_reg(CFG_TABLE_SIZE, size);
    setting_count++;
  endtask

  // Item driver: holds start high until the core takes the item.
  always @(posedge clk_i) begin : item_driver
    bit idle_now;
    if (rst_ni) begin
      if (start_i && !busy_o) begin
        if (driven_item.cmd == CMD_LOAD) begin
          book_words[driven_item.addr] = driven_item.value;
          load_count++;
        end else begin
          expected_index.push_back(nearest_codeword(driven_item));
          search_count++;
          if (cur_mode == MODE_QUAD) quad_count++;
        end
        items_accepted++;
      end
      if (!start_i || !busy_o) begin
        idle_now = ($urandom_range(0, 99) < 6) &&
                   !(items_accepted >= QUIET_FROM && items_accepted < QUIET_TO);
        if (pending_items.size() != 0 && !idle_now) begin
          driven_item = pending_items.pop_front();
          start_i      <= 1'b1;
          cmd_i        <= driven_item.cmd;
          load_addr_i  <= driven_item.addr;
          load_value_i <= driven_item.value;
          new_gain0_i  <= driven_item.gain0;
          old_pitch0_i <= driven_item.pitch0;
          new_gain1_i  <= driven_item.gain1;
          old_pitch1_i <= driven_item.pitch1;
        end else begin
          start_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : result_monitor
    index_t want;
    if (rst_ni && done_o === 1'b1) begin
      if (expected_index.size() == 0) begin
        $error("best_index: result with no search outstanding, expected none, actual %0d",
               best_index_o);
        fail_count++;
      end else begin
        want = expected_index.pop_front();
        checked_count++;
        if (best_index_o !== want) begin
          $error("best_index mismatch: expected %0d, actual %0d", want, best_index_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o === 1'b1 || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("gain_codebook_nearest_search_core regression: fail");
    $finish;
  end

  initial begin : stimulus
    int unsigned random_end;
    int unsigned span;
    int unsigned phase_len;
    int unsigned pick;
    mode_t       mode;
    cfg_data_t   size;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The whole store is written first, so no search ever reads a fresh entry.
    for (int unsigned a = 0; a < BOOK_WORDS; a++) begin
      queue_load(a, sample_t'($urandom()));
    end
    queue_load(0, 16'sh7FFF);
    queue_load(1, 16'sh8000);
    queue_search(16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000);
    queue_search(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);

    // Scalar: every word at the far extreme, so nothing beats the distance cap.
    apply_setting(MODE_SCALAR, 9'd4);
    for (int unsigned a = 0; a < 4; a++) queue_load(a, 16'sh8000);
    queue_search(16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0000);
    queue_load(2, 16'sh8001);
    queue_search(16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0000);
    // Equal distances: the lower index has to win.
    queue_load(1, 16'sd50);
    queue_load(3, 16'sd50);
    queue_search(16'sd100, 16'sh0000, 16'sh0000, 16'sh0000);
    queue_search(16'sd0, 16'sh0000, 16'sh0000, 16'sh0000);

    apply_setting(MODE_SCALAR, 9'd0);
    queue_search(16'sd50, 16'sh0000, 16'sh0000, 16'sh0000);

    // Oversized table count saturates to the search limit.
    apply_setting(MODE_PAIR_Q11, 9'd511);
    queue_search(16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0000);
    queue_search(16'sh8000, 16'sh7FFF, 16'sh0000, 16'sh0000);

    // A single word holds no complete pair; an odd count drops its last word.
    apply_setting(MODE_PAIR_Q12, 9'd1);
    queue_search(16'sd50, 16'sd50, 16'sh0000, 16'sh0000);
    apply_setting(MODE_PAIR_Q12, 9'd3);
    queue_search(16'sd50, 16'sh8000, 16'sh0000, 16'sh0000);

    apply_setting(MODE_QUAD, 9'd256);
    queue_search(16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF);
    queue_search(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000);

    random_end = items_queued + RANDOM_ITEMS;
    while (items_queued < random_end) begin
      pick = $urandom_range(0, 19);
      mode = (pick < 2) ? MODE_QUAD : mode_t'($urandom_range(0, 2));
      pick = $urandom_range(0, 19);
      case (pick)
        0:       size = 9'd0;
        1:       size = 9'd1;
        2:       size = cfg_data_t'($urandom_range(257, 511));
        3:       size = 9'd256;
        4, 5:    size = cfg_data_t'($urandom_range(100, 255));
        default: size = cfg_data_t'($urandom_range(2, 40));
      endcase
      apply_setting(mode, size);
      if (mode == MODE_QUAD) begin
        span      = BOOK_WORDS;
        phase_len = 6;
      end else begin
        span      = (size < 4) ? 4 : ((size > MAX_SEARCH) ? MAX_SEARCH : size);
        phase_len = $urandom_range(15, 50);
      end
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < 45) begin
          if ($urandom_range(0, 3) == 0) begin
            queue_load($urandom_range(0, BOOK_WORDS - 1), pick_sample(span));
          end else begin
            queue_load($urandom_range(0, span - 1), pick_sample(span));
          end
        end else begin
          queue_search(pick_sample(span), pick_sample(span), pick_sample(span),
                       pick_sample(span));
        end
      end
    end

    wait_quiet();
    repeat (END_CYCLES) @(posedge clk_i);
    $display("Covered %0d loads and %0d searches (%0d in quad mode) over %0d register settings;",
             load_count, search_count, quad_count, setting_count);
    $display("%0d results checked, %0d mismatches.", checked_count, fail_count);
    if (fail_count == 0) begin
      $display("gain_codebook_nearest_search_core regression: pass");
    end else begin
      $display("gain_codebook_nearest_search_core regression: fail");
    end
    $finish;
  end

endmodule
